@@ rtl/tvs_pkg.sv @@
// Shared types, constants and the microcode ROM of the trilinear volume sampler.
package tvs_pkg;

    localparam int MAX_X_DEF     = 32;
    localparam int MAX_Y_DEF     = 32;
    localparam int MAX_Z_DEF     = 32;
    localparam int FRAC_BITS_DEF = 8;

    localparam int SIZE_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [1:0] ST_SAMPLED = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_WRITTEN = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam int PC_W      = 4;
    localparam int N_CORNERS = 8;
    localparam int ACC_LAG   = 3;

    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc STEP_IDLE   = t_pc'(0);
    localparam t_pc STEP_OFFS   = t_pc'(1);
    localparam t_pc STEP_R0     = t_pc'(2);
    localparam t_pc STEP_RD_END = t_pc'(2 + N_CORNERS);
    localparam t_pc STEP_ACC0   = t_pc'(2 + ACC_LAG);
    localparam t_pc STEP_RES    = t_pc'(2 + N_CORNERS + ACC_LAG);
    localparam t_pc STEP_WR     = t_pc'(3 + N_CORNERS + ACC_LAG);
    localparam t_pc STEP_SPARE  = t_pc'(4 + N_CORNERS + ACC_LAG);

    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT,
        C_JUMP,
        C_IFWRITE,
        C_IFOUT
    } t_cond;

    typedef enum logic [1:0] {
        O_NONE,
        O_SAMPLE,
        O_WRITE
    } t_osel;

    typedef struct packed {
        t_cond      cond;
        t_pc        target;
        logic       ld_offs;
        logic       rd_en;
        logic [2:0] rd_c;
        logic       mul_i;
        logic       acc_en;
        logic       wr_en;
        t_osel      osel;
    } t_uword;

    typedef struct packed {
        logic is_write;
        logic bad;
    } t_seq_flags;

    // Corner c = {k, j, i}; corner c is read into r_rdata at STEP_R0 + c, scaled by
    // the x weight into r_p1, by the yz weight into r_p2, then summed into r_acc.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        t_pc    d;
        w        = '0;
        w.cond   = C_NEXT;
        w.target = STEP_IDLE;
        w.osel   = O_NONE;
        d        = pc - STEP_R0;
        if (pc >= STEP_R0 && pc < STEP_RD_END) begin
            w.rd_en = 1'b1;
            w.rd_c  = d[2:0];
        end
        if (pc > STEP_R0 && pc <= STEP_RD_END) begin
            w.mul_i = ~d[0];
        end
        if (pc >= STEP_ACC0 && pc < STEP_RES) begin
            w.acc_en = 1'b1;
        end
        case (pc)
            STEP_IDLE: begin
                w.cond = C_WAIT;
            end
            STEP_OFFS: begin
                w.ld_offs = 1'b1;
                w.cond    = C_IFWRITE;
                w.target  = STEP_WR;
            end
            STEP_R0: begin
                w.cond   = C_IFOUT;
                w.target = STEP_RES;
            end
            STEP_RES: begin
                w.osel = O_SAMPLE;
                w.cond = C_JUMP;
            end
            STEP_WR: begin
                w.wr_en = 1'b1;
                w.osel  = O_WRITE;
                w.cond  = C_JUMP;
            end
            STEP_SPARE: begin
                w.cond = C_JUMP;
            end
            default: begin
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/tvs_useq.sv @@
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module tvs_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  tvs_pkg::t_seq_flags  i_flags,
    output tvs_pkg::t_uword      o_uword,
    output logic                 o_idle
);

    tvs_pkg::t_pc    r_pc;
    tvs_pkg::t_pc    n_pc;
    tvs_pkg::t_pc    pc_inc;
    tvs_pkg::t_uword uw;

    assign uw     = tvs_pkg::ucode(r_pc);
    assign pc_inc = r_pc + tvs_pkg::t_pc'(1);

    always_comb begin
        case (uw.cond)
            tvs_pkg::C_NEXT:    n_pc = pc_inc;
            tvs_pkg::C_WAIT:    n_pc = i_go ? pc_inc : r_pc;
            tvs_pkg::C_JUMP:    n_pc = uw.target;
            tvs_pkg::C_IFWRITE: n_pc = i_flags.is_write ? uw.target : pc_inc;
            tvs_pkg::C_IFOUT:   n_pc = i_flags.bad ? uw.target : pc_inc;
            default:            n_pc = tvs_pkg::STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tvs_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;
    assign o_idle  = (r_pc == tvs_pkg::STEP_IDLE);

endmodule

@@ rtl/trilinear_volume_sampler.sv @@
// Top level: byte volume memory, axis setup and multiply-accumulate datapath.
//
// Holds a MAX_X x MAX_Y x MAX_Z byte volume and answers one command at a time:
// a write stores one voxel, a sample returns the trilinear blend of the eight
// neighbours with FRAC_BITS fraction bits. A command is taken at a clock edge
// with start high and busy low; its single result shows on o_valid for one
// cycle and cannot be held off. A sample reads its eight corners one per cycle
// through the single-port volume memory, and the last one drains through a
// three-stage multiply-accumulate before the result is registered. A write
// passes only the offset and write steps; a sample that falls outside the
// volume skips the reads and the accumulate. After reset the memory is swept
// to zero, one voxel a cycle, all MAX_X*MAX_Y*MAX_Z voxels (32768 by default);
// busy stays high until then, while size registers may already be written.
module trilinear_volume_sampler #(
    parameter int MAX_X     = tvs_pkg::MAX_X_DEF,
    parameter int MAX_Y     = tvs_pkg::MAX_Y_DEF,
    parameter int MAX_Z     = tvs_pkg::MAX_Z_DEF,
    parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [4:0]                          i_voxel_x,
    input  logic [4:0]                          i_voxel_y,
    input  logic [4:0]                          i_voxel_z,
    input  logic [7:0]                          i_voxel_value,
    input  logic signed [15:0]                  i_sample_x,
    input  logic signed [15:0]                  i_sample_y,
    input  logic signed [15:0]                  i_sample_z,
    output logic                                o_valid,
    output logic [15:0]                         o_sample_value,
    output logic [1:0]                          o_status,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tvs_pkg::SIZE_W-1:0]          i_cfg_data
);

    localparam int PLANE     = MAX_X * MAX_Y;
    localparam int VOL_DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW        = $clog2(VOL_DEPTH);
    localparam int WW        = FRAC_BITS + 1;
    localparam int P1_W      = 8 + WW;
    localparam int WYZ_W     = 2 * WW;
    localparam int ACC_W     = 8 + 3 * WW;
    localparam int SW        = tvs_pkg::SIZE_W;

    typedef struct packed {
        logic          ok;
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;
        logic [WW-1:0] w0;
        logic [WW-1:0] w1;
    } t_axis;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] raw,
                                                 input int unsigned lim);
        logic [SW-1:0] v;
        v = raw;
        if (v == '0) v = SW'(1);
        if (32'(v) > lim) v = SW'(lim);
        return v;
    endfunction

    function automatic t_axis split_axis(input logic [15:0] p, input logic [SW-1:0] size);
        t_axis                   s;
        logic [SW+FRAC_BITS-1:0] lim;
        logic [SW:0]             nxt;
        lim  = {size - SW'(1), FRAC_BITS'(0)};
        s.ok = !p[15] && !(32'(p[14:0]) > 32'(lim));
        s.lo = SW'(p[14:0] >> FRAC_BITS);
        nxt  = {1'b0, s.lo} + (SW+1)'(1);
        s.hi = (nxt < {1'b0, size}) ? nxt[SW-1:0] : s.lo;
        s.w1 = WW'(p[FRAC_BITS-1:0]);
        s.w0 = (WW'(1) << FRAC_BITS) - s.w1;
        return s;
    endfunction

    // configuration
    logic [SW-1:0] r_size_x;
    logic [SW-1:0] r_size_y;
    logic [SW-1:0] r_size_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= clamp_size(SW'(32), MAX_X);
            r_size_y <= clamp_size(SW'(32), MAX_Y);
            r_size_z <= clamp_size(SW'(32), MAX_Z);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tvs_pkg::REG_SIZE_X: r_size_x <= clamp_size(i_cfg_data, MAX_X);
                tvs_pkg::REG_SIZE_Y: r_size_y <= clamp_size(i_cfg_data, MAX_Y);
                tvs_pkg::REG_SIZE_Z: r_size_z <= clamp_size(i_cfg_data, MAX_Z);
                default: begin
                end
            endcase
        end
    end

    // sequencer
    tvs_pkg::t_uword     uw;
    tvs_pkg::t_seq_flags flags;
    logic                seq_idle;
    logic                accept;
    logic                r_clr;
    logic [AW-1:0]       r_clr_addr;
    logic                r_func;
    logic                r_bad;

    assign busy           = r_clr || !seq_idle;
    assign accept         = start && !busy;
    assign flags.is_write = !r_func;
    assign flags.bad      = r_bad;

    tvs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_flags (flags),
        .o_uword (uw),
        .o_idle  (seq_idle)
    );

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(VOL_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    // axis setup at accept
    t_axis         ax;
    t_axis         ay;
    t_axis         az;
    logic [SW-1:0] r_x [2];
    logic [SW-1:0] r_y [2];
    logic [SW-1:0] r_z [2];
    logic [WW-1:0] r_wx [2];
    logic [WW-1:0] r_wy [2];
    logic [WW-1:0] r_wz [2];
    logic [7:0]    r_vval;
    logic          wr_ok;

    assign ax    = split_axis(i_sample_x, r_size_x);
    assign ay    = split_axis(i_sample_y, r_size_y);
    assign az    = split_axis(i_sample_z, r_size_z);
    assign wr_ok = ({1'b0, i_voxel_x} < r_size_x) && ({1'b0, i_voxel_y} < r_size_y) &&
                   ({1'b0, i_voxel_z} < r_size_z);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_vval <= i_voxel_value;
            if (!i_func) begin
                r_x[0] <= {1'b0, i_voxel_x};
                r_y[0] <= {1'b0, i_voxel_y};
                r_z[0] <= {1'b0, i_voxel_z};
                r_x[1] <= {1'b0, i_voxel_x};
                r_y[1] <= {1'b0, i_voxel_y};
                r_z[1] <= {1'b0, i_voxel_z};
                r_bad  <= !wr_ok;
            end else begin
                r_x[0]  <= ax.lo;
                r_x[1]  <= ax.hi;
                r_y[0]  <= ay.lo;
                r_y[1]  <= ay.hi;
                r_z[0]  <= az.lo;
                r_z[1]  <= az.hi;
                r_wx[0] <= ax.w0;
                r_wx[1] <= ax.w1;
                r_wy[0] <= ay.w0;
                r_wy[1] <= ay.w1;
                r_wz[0] <= az.w0;
                r_wz[1] <= az.w1;
                r_bad   <= !(ax.ok && ay.ok && az.ok);
            end
        end
    end

    // row and plane offsets
    logic [AW-1:0] r_zoff [2];
    logic [AW-1:0] r_yoff [2];
    logic [AW-1:0] corner_addr;

    always_ff @(posedge i_clk) begin
        if (uw.ld_offs) begin
            for (int k = 0; k < 2; k++) begin
                r_zoff[k] <= AW'(32'(r_z[k]) * 32'(PLANE));
                r_yoff[k] <= AW'(32'(r_y[k]) * 32'(MAX_X));
            end
        end
    end

    assign corner_addr = r_zoff[uw.rd_c[2]] + r_yoff[uw.rd_c[1]] + AW'(r_x[uw.rd_c[0]]);

    // volume memory, one port
    logic [7:0]    r_mem [VOL_DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic          mem_we;
    logic          mem_re;

    assign mem_addr  = r_clr ? r_clr_addr : corner_addr;
    assign mem_wdata = r_clr ? 8'd0 : r_vval;
    assign mem_we    = r_clr || (uw.wr_en && !r_bad);
    assign mem_re    = uw.rd_en && !r_bad && !r_clr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // multiply-accumulate: v * wx, then * (wy * wz), then sum
    logic [WYZ_W-1:0] r_wyz;
    logic [WYZ_W-1:0] r_wyz1;
    logic [P1_W-1:0]  r_p1;
    logic [ACC_W-1:0] r_p2;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] acc_shift;

    always_ff @(posedge i_clk) begin
        if (uw.rd_en) begin
            r_wyz <= WYZ_W'(r_wy[uw.rd_c[1]]) * WYZ_W'(r_wz[uw.rd_c[2]]);
        end
        r_wyz1 <= r_wyz;
        r_p1   <= P1_W'(r_rdata) * P1_W'(r_wx[uw.mul_i]);
        r_p2   <= ACC_W'(r_p1) * ACC_W'(r_wyz1);
        if (uw.ld_offs) begin
            r_acc <= '0;
        end else if (uw.acc_en) begin
            r_acc <= r_acc + r_p2;
        end
    end

    assign acc_shift = r_acc >> (2 * FRAC_BITS);

    // result register
    logic        r_valid;
    logic [15:0] r_value;
    logic [1:0]  r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (uw.osel != tvs_pkg::O_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (uw.osel)
            tvs_pkg::O_SAMPLE: begin
                r_value  <= r_bad ? 16'd0 : 16'(acc_shift);
                r_status <= r_bad ? tvs_pkg::ST_OUTSIDE : tvs_pkg::ST_SAMPLED;
            end
            tvs_pkg::O_WRITE: begin
                r_value  <= 16'd0;
                r_status <= r_bad ? tvs_pkg::ST_IGNORED : tvs_pkg::ST_WRITTEN;
            end
            default: begin
            end
        endcase
    end

    assign o_valid        = r_valid;
    assign o_sample_value = r_value;
    assign o_status       = r_status;

endmodule

@@ rtl/tvs_chk.sv @@
// Port-level checker for the trilinear volume sampler, bound to the top level.
module tvs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_func,
    input logic        o_valid,
    input logic [15:0] o_sample_value,
    input logic [1:0]  o_status
);

    // a result only follows a cycle of work
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // one command gives one single-cycle strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // a write result follows its write transfer through the offset and write steps
    a_write_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == tvs_pkg::ST_WRITTEN || o_status == tvs_pkg::ST_IGNORED))
        |-> $past(start && !busy && !i_func, 3))
        else $error("write result without matching write transfer");

    // only a sample inside the volume carries a value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tvs_pkg::ST_SAMPLED) |-> (o_sample_value == 16'd0))
        else $error("nonzero value on write or outside result");

endmodule

bind trilinear_volume_sampler tvs_chk u_tvs_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_func         (i_func),
    .o_valid        (o_valid),
    .o_sample_value (o_sample_value),
    .o_status       (o_status)
);
